/* rtl/mbrf_pkg.sv */
package mbrf_pkg;

   localparam logic [2:0] MODE_READ_HOLDING = 3'd0;
   localparam logic [2:0] MODE_READ_INPUT   = 3'd1;
   localparam logic [2:0] MODE_WRITE_SINGLE = 3'd2;
   localparam logic [2:0] MODE_WRITE_MULTI  = 3'd3;
   localparam logic [2:0] MODE_DATA_WORD    = 3'd4;

   localparam logic [7:0] FC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FC_READ_INPUT   = 8'h04;
   localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [6:0] REG_LIMIT_MAX   = 7'd123;
   localparam logic [6:0] MAX_WRITE_RESET = 7'd20;

   typedef enum logic [2:0] {
      CMD_FULL,
      CMD_MULTI,
      CMD_DATA,
      CMD_DATA_LAST,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   unit_id;
      logic [7:0]   code;
      logic [15:0]  reg_addr;
      logic [15:0]  count_or_value;
      logic [15:0]  data_word;
   } cmd_type;

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/modbus_rtu_request_framer.sv */
// Builds Modbus RTU master request frames and delivers them one byte per result item, each
// frame closed by its CRC-16 sent low byte first. A read or write-single item yields eight
// bytes, a write-multiple header seven, a data word two (four for the last word of a frame,
// which carries the CRC) and a rejected item one; the serialiser in the back end emits one
// byte per cycle unless a waiting byte is stalled by rsp_pop, and it takes the next queued
// item as it sends the last byte of the current one. A two-entry command queue lets the input
// side take items while earlier frames are still being sent. The user must write the register
// max_write_regs only while the block is idle; the block itself does not enforce it.
module modbus_rtu_request_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_unit_id,
   input  logic [15:0] req_reg_addr,
   input  logic [15:0] req_count_or_value,
   input  logic [15:0] req_data_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_last,
   output logic        rsp_request_error,
   input  logic        csr_write_en,
   input  logic [6:0]  csr_write_data
);
   import mbrf_pkg::*;

   cmd_type push_data, pop_data;
   logic    q_push, q_full, q_pop, q_empty;

   mbrf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_mode           (req_mode),
      .req_unit_id        (req_unit_id),
      .req_reg_addr       (req_reg_addr),
      .req_count_or_value (req_count_or_value),
      .req_data_word      (req_data_word),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .q_push             (q_push),
      .q_data             (push_data),
      .q_full             (q_full)
   );

   mbrf_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   mbrf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_data            (pop_data),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_request_error (rsp_request_error)
   );

endmodule

/* rtl/mbrf_front.sv */
module mbrf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [2:0]             req_mode,
   input  logic [7:0]             req_unit_id,
   input  logic [15:0]            req_reg_addr,
   input  logic [15:0]            req_count_or_value,
   input  logic [15:0]            req_data_word,
   input  logic                   csr_write_en,
   input  logic [6:0]             csr_write_data,
   output logic                   q_push,
   output mbrf_pkg::cmd_type      q_data,
   input  logic                   q_full
);
   import mbrf_pkg::*;

   logic [6:0] max_regs_ff, max_regs_in;
   logic       open_ff, open_in;
   logic [6:0] remaining_ff, remaining_in;
   logic [6:0] limit;
   logic       bad_count;
   logic       accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept;

   always_comb begin
      limit        = (max_regs_ff > REG_LIMIT_MAX) ? REG_LIMIT_MAX : max_regs_ff;
      bad_count    = (req_count_or_value == 16'd0) ||
                     (req_count_or_value > {9'd0, limit});
      max_regs_in  = csr_write_en ? csr_write_data : max_regs_ff;
      open_in      = open_ff;
      remaining_in = remaining_ff;

      q_data.kind           = CMD_ERROR;
      q_data.unit_id        = req_unit_id;
      q_data.reg_addr       = req_reg_addr;
      q_data.count_or_value = req_count_or_value;
      q_data.data_word      = req_data_word;
      q_data.code           = FC_WRITE_MULTI;

      if (req_mode inside {MODE_READ_HOLDING, MODE_READ_INPUT, MODE_WRITE_SINGLE}) begin
         q_data.kind = CMD_FULL;
         open_in     = 1'b0;
         remaining_in = 7'd0;
         case (req_mode)
            MODE_READ_HOLDING: q_data.code = FC_READ_HOLDING;
            MODE_READ_INPUT:   q_data.code = FC_READ_INPUT;
            default:           q_data.code = FC_WRITE_SINGLE;
         endcase
      end else if (req_mode == MODE_WRITE_MULTI) begin
         if (bad_count) begin
            q_data.kind  = CMD_ERROR;
            open_in      = 1'b0;
            remaining_in = 7'd0;
         end else begin
            q_data.kind  = CMD_MULTI;
            open_in      = 1'b1;
            remaining_in = req_count_or_value[6:0];
         end
      end else if (req_mode == MODE_DATA_WORD && open_ff && remaining_ff != 7'd0) begin
         remaining_in = remaining_ff - 7'd1;
         if (remaining_ff == 7'd1) begin
            q_data.kind = CMD_DATA_LAST;
            open_in     = 1'b0;
         end else begin
            q_data.kind = CMD_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_regs_ff  <= MAX_WRITE_RESET;
         open_ff      <= 1'b0;
         remaining_ff <= 7'd0;
      end else begin
         max_regs_ff <= max_regs_in;
         if (accept) begin
            open_ff      <= open_in;
            remaining_ff <= remaining_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_open_has_words: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> remaining_ff != 7'd0)
      else $error("open write frame with no words owed");
   a_reject_stray: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_DATA_WORD && !open_ff |-> q_data.kind == CMD_ERROR)
      else $error("data word outside a frame not rejected");
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      accept && q_data.kind == CMD_DATA_LAST |=> !open_ff)
      else $error("frame still open after its last word");
`endif

endmodule

/* rtl/mbrf_cmd_queue.sv */
module mbrf_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mbrf_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output mbrf_pkg::cmd_type pop_data,
   output logic              empty
);
   import mbrf_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* rtl/mbrf_back.sv */
module mbrf_back (
   input  logic              clock,
   input  logic              reset,
   input  mbrf_pkg::cmd_type q_data,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_frame_byte,
   output logic              rsp_frame_last,
   output logic              rsp_request_error
);
   import mbrf_pkg::*;

   cmd_type     cmd_ff, cmd_in;
   logic        busy_ff, busy_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        out_err_ff, out_err_in;

   logic        advance, take, is_hdr, at_last, crc_byte, frame_end;
   logic [2:0]  last_idx;
   logic [7:0]  cur_byte;
   logic [15:0] crc_base;

   assign rsp_empty         = !out_valid_ff;
   assign rsp_frame_byte    = out_byte_ff;
   assign rsp_frame_last    = out_last_ff;
   assign rsp_request_error = out_err_ff;

   always_comb begin
      advance  = !out_valid_ff || rsp_pop;
      is_hdr   = (cmd_ff.kind == CMD_FULL) || (cmd_ff.kind == CMD_MULTI);
      crc_base = (is_hdr && idx_ff == 3'd0) ? CRC_INIT : crc_ff;

      case (cmd_ff.kind)
         CMD_FULL:      last_idx = 3'd7;
         CMD_MULTI:     last_idx = 3'd6;
         CMD_DATA:      last_idx = 3'd1;
         CMD_DATA_LAST: last_idx = 3'd3;
         default:       last_idx = 3'd0;
      endcase
      at_last   = (idx_ff == last_idx);
      crc_byte  = ((cmd_ff.kind == CMD_FULL) && idx_ff >= 3'd6) ||
                  ((cmd_ff.kind == CMD_DATA_LAST) && idx_ff >= 3'd2);
      frame_end = at_last && (cmd_ff.kind == CMD_FULL || cmd_ff.kind == CMD_DATA_LAST ||
                              cmd_ff.kind == CMD_ERROR);

      case (cmd_ff.kind)
         CMD_FULL, CMD_MULTI: begin
            case (idx_ff)
               3'd0: cur_byte = cmd_ff.unit_id;
               3'd1: cur_byte = cmd_ff.code;
               3'd2: cur_byte = cmd_ff.reg_addr[15:8];
               3'd3: cur_byte = cmd_ff.reg_addr[7:0];
               3'd4: cur_byte = cmd_ff.count_or_value[15:8];
               3'd5: cur_byte = cmd_ff.count_or_value[7:0];
               3'd6: cur_byte = (cmd_ff.kind == CMD_MULTI) ?
                                {cmd_ff.count_or_value[6:0], 1'b0} : crc_ff[7:0];
               default: cur_byte = crc_ff[15:8];
            endcase
         end
         CMD_DATA, CMD_DATA_LAST: begin
            case (idx_ff)
               3'd0:    cur_byte = cmd_ff.data_word[15:8];
               3'd1:    cur_byte = cmd_ff.data_word[7:0];
               3'd2:    cur_byte = crc_ff[7:0];
               default: cur_byte = crc_ff[15:8];
            endcase
         end
         default: cur_byte = 8'h00;
      endcase

      take   = advance && (!busy_ff || at_last);
      q_pop  = take && !q_empty;

      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      idx_in  = idx_ff;
      crc_in  = crc_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      if (advance) begin
         out_valid_in = busy_ff;
         out_byte_in  = cur_byte;
         out_last_in  = frame_end;
         out_err_in   = (cmd_ff.kind == CMD_ERROR);
         if (busy_ff) begin
            idx_in = idx_ff + 3'd1;
            if (crc_byte) begin
               crc_in = at_last ? CRC_INIT : crc_ff;
            end else if (cmd_ff.kind != CMD_ERROR) begin
               crc_in = crc_add(crc_base, cur_byte);
            end
         end
      end
      if (take) begin
         busy_in = !q_empty;
         cmd_in  = q_data;
         idx_in  = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 3'd0;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_err_ff |-> out_last_ff && out_byte_ff == 8'h00)
      else $error("error item without last flag or with nonzero byte");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= last_idx)
      else $error("byte index ran past the end of its command");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(out_byte_ff))
      else $error("waiting result item lost while stalled");
   a_crc_closed: assert property (@(posedge clock) disable iff (reset)
      advance && busy_ff && frame_end && cmd_ff.kind != CMD_ERROR |=> crc_ff == CRC_INIT)
      else $error("running CRC not restored after a frame");
`endif

endmodule
